// ===== rtl/itaf_pkg.sv =====
// Shared types, codes and character tables for the integer-to-ASCII formatter.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package itaf_pkg;

  // Format codes as they arrive on the op port.
  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_PTR  = 2'd3;

  // ASCII codes used for fixed text.
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_L      = 8'h6c;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // Digit counts for the two number bases, and the bit count of the decimal converter.
  localparam logic [5:0] DEC_BITS   = 6'd32;
  localparam logic [5:0] DEC_DIGITS = 6'd10;
  localparam logic [5:0] HEX_DIGITS = 6'd16;

  // Classified job kinds passed from the front end to the back end.
  typedef enum logic [1:0] {
    KIND_DEC,
    KIND_HEX,
    KIND_PTR,
    KIND_NIL
  } kind_t;

  // One queued job.
  typedef struct packed {
    kind_t       kind;
    logic        neg;
    logic        upper;
    logic [63:0] mag;
  } job_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_PREFIX,
    ST_DIGITS
  } state_t;

  // Maps a digit value to its ASCII code in the selected alphabet.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

  // Character of the fixed prefix or of the null-pointer text at a position.
  function automatic logic [7:0] prefix_char(input kind_t kind, input logic [2:0] idx);
    logic [7:0] c;
    c = CH_ZERO;
    case (kind)
      KIND_DEC: c = CH_MINUS;
      KIND_PTR: c = (idx == 3'd0) ? CH_ZERO : CH_X;
      KIND_NIL: begin
        case (idx)
          3'd0: c = CH_LPAREN;
          3'd1: c = CH_N;
          3'd2: c = CH_I;
          3'd3: c = CH_L;
          default: c = CH_RPAREN;
        endcase
      end
      default: c = CH_ZERO;
    endcase
    prefix_char = c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_ascii_formatter_top.sv =====
// Integer-to-ASCII formatter: decimal, hex and pointer text, one character a cycle within
// each text. A two-entry queue lets starts run ahead while the back end is busy.
// Synchronous reset empties the queue and idles the sequencer; the receiver cannot stall.
`default_nettype none

module integer_to_ascii_formatter_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [63:0] value,
  input  wire logic        upper_case,
  output logic             valid,
  output logic [7:0]       char_code,
  output logic             is_last,
  output logic [4:0]       char_count
);
  import itaf_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t pop_job;

  assign busy = full;

  itaf_front u_front (
    .start      (start),
    .op         (op),
    .value      (value),
    .upper_case (upper_case),
    .full       (full),
    .push       (push),
    .job        (push_job)
  );

  itaf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (full),
    .empty    (empty)
  );

  itaf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .job        (pop_job),
    .pop        (pop),
    .valid      (valid),
    .char_code  (char_code),
    .is_last    (is_last),
    .char_count (char_count)
  );

endmodule

`default_nettype wire

// ===== rtl/itaf_front.sv =====
// Front end: classifies an incoming number by format and forms its magnitude.
// Depends on itaf_pkg.
`default_nettype none

module itaf_front (
  input  wire logic           start,
  input  wire logic [1:0]     op,
  input  wire logic [63:0]    value,
  input  wire logic           upper_case,
  input  wire logic           full,
  output logic                push,
  output itaf_pkg::job_t      job
);
  import itaf_pkg::*;

  logic [31:0] low;
  logic        is_neg;

  assign low    = value[31:0];
  assign is_neg = (op == OP_SDEC) && low[31];

  // A transfer happens whenever start is high and the queue has room.
  assign push = start && !full;

  // Decide the job kind and the magnitude to convert.
  always_comb begin
    job.upper = upper_case;
    job.neg   = is_neg;
    case (op)
      OP_SDEC: begin
        job.kind = KIND_DEC;
        job.mag  = {32'd0, is_neg ? (32'd0 - low) : low};
      end
      OP_UDEC: begin
        job.kind = KIND_DEC;
        job.mag  = {32'd0, low};
      end
      OP_HEX: begin
        job.kind = KIND_HEX;
        job.mag  = value;
      end
      default: begin
        job.kind = (value == 64'd0) ? KIND_NIL : KIND_PTR;
        job.mag  = value;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/itaf_queue.sv =====
// Two-entry job queue between the front end and the back end.
// Depends on itaf_pkg for the job type.
`default_nettype none

module itaf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire itaf_pkg::job_t push_job,
  input  wire logic           pop,
  output itaf_pkg::job_t      pop_job,
  output logic                full,
  output logic                empty
);
  import itaf_pkg::*;

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = mem[rptr];

  // Storage for queued jobs.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/itaf_back.sv =====
// Back end: bit-serial binary-to-BCD conversion, leading-zero trim and
// one-character-per-cycle emission. Depends on itaf_pkg.
`default_nettype none

module itaf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  input  wire itaf_pkg::job_t job,
  output logic                pop,
  output logic                valid,
  output logic [7:0]          char_code,
  output logic                is_last,
  output logic [4:0]          char_count
);
  import itaf_pkg::*;

  state_t      state, state_next;
  kind_t       kind, kind_next;
  logic        neg, neg_next;
  logic        upper, upper_next;
  logic [63:0] work, work_next;
  logic [31:0] bin, bin_next;
  logic [39:0] bcd, bcd_next;
  logic [39:0] bcd_adj;
  logic [5:0]  cnt, cnt_next;
  logic [2:0]  pre_idx, pre_idx_next;
  logic [4:0]  chars, chars_next;
  logic        valid_next;
  logic [7:0]  char_code_next;
  logic        is_last_next;
  logic [4:0]  char_count_next;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3) : bcd[4*i +: 4];
    end
  end

  // Sequencer next state and character output.
  always_comb begin
    state_next      = state;
    kind_next       = kind;
    neg_next        = neg;
    upper_next      = upper;
    work_next       = work;
    bin_next        = bin;
    bcd_next        = bcd;
    cnt_next        = cnt;
    pre_idx_next    = pre_idx;
    chars_next      = chars;
    valid_next      = 1'b0;
    char_code_next  = char_code;
    is_last_next    = 1'b0;
    char_count_next = char_count;
    pop             = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop          = 1'b1;
          kind_next    = job.kind;
          neg_next     = job.neg;
          upper_next   = job.upper;
          work_next    = job.mag;
          bin_next     = job.mag[31:0];
          bcd_next     = 40'd0;
          pre_idx_next = 3'd0;
          chars_next   = 5'd0;
          case (job.kind)
            KIND_DEC: begin
              cnt_next   = DEC_BITS;
              state_next = ST_CONV;
            end
            KIND_NIL: begin
              state_next = ST_PREFIX;
            end
            default: begin
              cnt_next   = HEX_DIGITS;
              state_next = ST_TRIM;
            end
          endcase
        end
      end
      ST_CONV: begin
        bcd_next = {bcd_adj[38:0], bin[31]};
        bin_next = {bin[30:0], 1'b0};
        cnt_next = cnt - 6'd1;
        if (cnt == 6'd1) begin
          work_next  = {bcd_adj[38:0], bin[31], 24'd0};
          cnt_next   = DEC_DIGITS;
          state_next = ST_TRIM;
        end
      end
      ST_TRIM: begin
        // Drop one leading zero digit a cycle, keeping at least one digit.
        if ((work[63:60] == 4'd0) && (cnt > 6'd1)) begin
          work_next = {work[59:0], 4'd0};
          cnt_next  = cnt - 6'd1;
        end else if ((kind == KIND_PTR) || ((kind == KIND_DEC) && neg)) begin
          state_next = ST_PREFIX;
        end else begin
          state_next = ST_DIGITS;
        end
      end
      ST_PREFIX: begin
        valid_next      = 1'b1;
        char_code_next  = prefix_char(kind, pre_idx);
        char_count_next = chars + 5'd1;
        chars_next      = chars + 5'd1;
        pre_idx_next    = pre_idx + 3'd1;
        if (kind == KIND_NIL) begin
          if (pre_idx == 3'd4) begin
            is_last_next = 1'b1;
            state_next   = ST_IDLE;
          end
        end else if ((kind == KIND_DEC) || (pre_idx == 3'd1)) begin
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        valid_next      = 1'b1;
        char_code_next  = digit_char(work[63:60], upper);
        char_count_next = chars + 5'd1;
        chars_next      = chars + 5'd1;
        work_next       = {work[59:0], 4'd0};
        cnt_next        = cnt - 6'd1;
        if (cnt == 6'd1) begin
          is_last_next = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    kind       <= kind_next;
    neg        <= neg_next;
    upper      <= upper_next;
    work       <= work_next;
    bin        <= bin_next;
    bcd        <= bcd_next;
    cnt        <= cnt_next;
    pre_idx    <= pre_idx_next;
    chars      <= chars_next;
    char_code  <= char_code_next;
    is_last    <= is_last_next;
    char_count <= char_count_next;
  end

endmodule

`default_nettype wire

// ===== test/tb_integer_to_ascii_formatter_top.sv =====
// Self-checking testbench for integer_to_ascii_formatter_top: predicts the character stream
// of every accepted number and checks each strobed character against it.
// Depends on itaf_pkg and the formatter RTL; needs no other file.
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter_top;
  import itaf_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_JOBS = 200;
  localparam int PHASE_JOBS = RANDOM_JOBS / 4;
  localparam int MAX_GAP = 20;

  // One number waiting to be sent, with its idle gap and drain request.
  typedef struct {
    logic [1:0]  fmt;
    logic [63:0] num;
    logic        upper;
    int          gap;
    bit          drain;
  } num_job_t;

  // One expected character.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic [4:0] count;
  } char_rec_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op = OP_SDEC;
  logic [63:0] value = 64'd0;
  logic        upper_case = 1'b0;
  logic        valid;
  logic [7:0]  char_code;
  logic        is_last;
  logic [4:0]  char_count;

  num_job_t  job_q[$];
  char_rec_t text_q[$];
  bit        took;
  bit        gap_armed;
  int        gap_left;
  int        cycles;
  int        errors;
  int        chars_checked;
  int        numbers_sent;
  int        fmt_seen[4];

  integer_to_ascii_formatter_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .value      (value),
    .upper_case (upper_case),
    .valid      (valid),
    .char_code  (char_code),
    .is_last    (is_last),
    .char_count (char_count)
  );

  always #1 clk = ~clk;

  // Counts a failure; only the first ten are described.
  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Appends the hex digits of a number, most significant first, without leading zeros.
  task automatic hex_digits(inout logic [7:0] txt[$], input logic [63:0] num,
                            input logic upper);
    logic [7:0] dig[$];
    logic [3:0] nib;
    do begin
      nib = num[3:0];
      if (nib < 4'd10) begin
        dig.push_front(CH_ZERO + {4'd0, nib});
      end else begin
        dig.push_front((upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, nib} - 8'd10);
      end
      num = num >> 4;
    end while (num != 64'd0);
    foreach (dig[k]) txt.push_back(dig[k]);
  endtask

  // Appends the decimal digits of a 32-bit magnitude, most significant first.
  task automatic dec_digits(inout logic [7:0] txt[$], input logic [31:0] mag);
    logic [7:0] dig[$];
    do begin
      dig.push_front(CH_ZERO + 8'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    foreach (dig[k]) txt.push_back(dig[k]);
  endtask

  // Works out the text of one number and queues its characters.
  task automatic format_text(input logic [1:0] fmt, input logic [63:0] num,
                             input logic upper);
    logic [7:0] txt[$];
    logic [31:0] low;
    char_rec_t rec;
    low = num[31:0];
    case (fmt)
      OP_SDEC: begin
        if (low[31]) begin
          txt.push_back(CH_MINUS);
          dec_digits(txt, 32'd0 - low);
        end else begin
          dec_digits(txt, low);
        end
      end
      OP_UDEC: dec_digits(txt, low);
      OP_HEX: hex_digits(txt, num, upper);
      default: begin
        if (num == 64'd0) begin
          txt.push_back(CH_LPAREN);
          txt.push_back(CH_N);
          txt.push_back(CH_I);
          txt.push_back(CH_L);
          txt.push_back(CH_RPAREN);
        end else begin
          txt.push_back(CH_ZERO);
          txt.push_back(CH_X);
          hex_digits(txt, num, upper);
        end
      end
    endcase
    foreach (txt[k]) begin
      rec.code = txt[k];
      rec.last = (k == txt.size() - 1);
      rec.count = 5'(k + 1);
      text_q.push_back(rec);
    end
  endtask

  task automatic add_job(input logic [1:0] fmt, input logic [63:0] num, input logic upper,
                         input int gap, input bit drain);
    num_job_t j;
    j.fmt = fmt;
    j.num = num;
    j.upper = upper;
    j.gap = gap;
    j.drain = drain;
    job_q.push_back(j);
  endtask

  // Random number shaped so that short and long texts both come up often.
  function automatic logic [63:0] pick_number();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: r = 64'd0;
      1: r = '1;
      2: r = {$urandom, 32'h8000_0000};
      3: r = {$urandom, 32'h7fff_ffff};
      4, 5, 6: r = r >> $urandom_range(63);
      default: ;
    endcase
    return r;
  endfunction

  // Idle gap before a transfer when the sender idles pct cycles out of a hundred.
  function automatic int pick_gap(input int pct);
    int g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  // Stimulus: directed corner numbers, then four phases of random numbers.
  initial begin
    int idle_pct[4];
    rst = 1'b1;
    idle_pct = '{0, 46, 0, 23};

    // Signed decimal: zero, one, minus one, both 32-bit extremes, ignored high bits.
    add_job(OP_SDEC, 64'd0, 1'b0, 0, 1'b0);
    add_job(OP_SDEC, 64'd1, 1'b0, 0, 1'b0);
    add_job(OP_SDEC, 64'h0000_0000_ffff_ffff, 1'b0, 0, 1'b0);
    add_job(OP_SDEC, 64'h0000_0000_7fff_ffff, 1'b1, 0, 1'b0);
    add_job(OP_SDEC, 64'hffff_ffff_8000_0000, 1'b0, 0, 1'b0);
    add_job(OP_SDEC, 64'hdead_beef_0000_0005, 1'b1, 0, 1'b0);
    // Unsigned decimal.
    add_job(OP_UDEC, 64'hffff_ffff_0000_0000, 1'b0, 0, 1'b0);
    add_job(OP_UDEC, 64'hffff_ffff_ffff_ffff, 1'b0, 0, 1'b0);
    add_job(OP_UDEC, 64'd1000000000, 1'b0, 0, 1'b0);
    add_job(OP_UDEC, 64'd9, 1'b1, 0, 1'b0);
    add_job(OP_UDEC, 64'h0000_0000_8000_0000, 1'b0, 0, 1'b0);
    // Hexadecimal in both alphabets.
    add_job(OP_HEX, 64'd0, 1'b0, 0, 1'b0);
    add_job(OP_HEX, 64'd1, 1'b1, 0, 1'b0);
    add_job(OP_HEX, '1, 1'b0, 0, 1'b0);
    add_job(OP_HEX, '1, 1'b1, 0, 1'b0);
    add_job(OP_HEX, 64'hfedc_ba98_7654_3210, 1'b0, 0, 1'b0);
    add_job(OP_HEX, 64'hfedc_ba98_7654_3210, 1'b1, 0, 1'b0);
    add_job(OP_HEX, 64'h8000_0000_0000_0000, 1'b0, 0, 1'b0);
    // Pointer: null text, shortest and longest forms.
    add_job(OP_PTR, 64'd0, 1'b0, 0, 1'b0);
    add_job(OP_PTR, 64'd0, 1'b1, 0, 1'b0);
    add_job(OP_PTR, 64'd1, 1'b0, 0, 1'b0);
    add_job(OP_PTR, '1, 1'b1, 0, 1'b0);
    add_job(OP_PTR, 64'h0000_0000_00ab_cdef, 1'b0, 0, 1'b0);
    add_job(OP_PTR, 64'h8000_0000_0000_0000, 1'b1, 0, 1'b0);

    // Random phases; each starts after the block has drained, one more drain mid-phase.
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < PHASE_JOBS; n++) begin
        add_job(2'($urandom_range(3)), pick_number(), 1'($urandom_range(1)),
                pick_gap(idle_pct[ph]), n == 0 || n == PHASE_JOBS / 2);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last transfer, then for every character, then for stray output.
    while (job_q.size() != 0 || start) @(posedge clk);
    while (text_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (text_q.size() != 0) begin
      flag_error($sformatf("%0d characters never arrived", text_q.size()));
    end

    $display("Sent %0d numbers: %0d signed, %0d unsigned, %0d hex, %0d pointer.",
             numbers_sent, fmt_seen[OP_SDEC], fmt_seen[OP_UDEC], fmt_seen[OP_HEX],
             fmt_seen[OP_PTR]);
    $display("Checked %0d characters, %0d failures.", chars_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Driver: presents the next number once the previous transfer is done.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (job_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        if (!gap_armed) begin
          gap_left = job_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (job_q[0].drain && text_q.size() != 0) begin
          start <= 1'b0;
        end else begin
          op <= job_q[0].fmt;
          value <= job_q[0].num;
          upper_case <= job_q[0].upper;
          void'(job_q.pop_front());
          gap_armed = 1'b0;
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: records transfers and checks each strobed character.
  always @(posedge clk) begin
    char_rec_t want;
    char_rec_t got;
    took <= !rst && start && !busy;
    if (!rst) begin
      if (start && !busy) begin
        format_text(op, value, upper_case);
        fmt_seen[op]++;
        numbers_sent++;
      end
      if (valid) begin
        got = {char_code, is_last, char_count};
        chars_checked++;
        if (text_q.size() == 0) begin
          flag_error($sformatf("unexpected character: code %h last %b count %0d",
                               char_code, is_last, char_count));
        end else begin
          want = text_q.pop_front();
          if (got !== want) begin
            flag_error($sformatf(
              "character mismatch: expected code %h last %b count %0d, got %h %b %0d",
              want.code, want.last, want.count, char_code, is_last, char_count));
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d characters pending.",
               cycles, text_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
